// File: hdl/bft_pkg.sv
`default_nettype none

package bft_pkg;

  localparam logic [1:0] OP_ORIGIN = 2'd0;
  localparam logic [1:0] OP_DRAW   = 2'd1;
  localparam logic [1:0] OP_FONT   = 2'd2;

  localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
  localparam logic [1:0] REG_TRANS_KEY     = 2'd2;

  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_FIRST   = 8'd32;
  localparam logic [7:0] CH_UNKNOWN = 8'd63;

  localparam int unsigned GLYPH_DIM     = 8;
  localparam int unsigned GLYPH_PIXELS  = GLYPH_DIM * GLYPH_DIM;
  localparam int unsigned PIX_CNT_W     = $clog2(GLYPH_PIXELS);
  localparam int unsigned ROW_SEL_W     = $clog2(GLYPH_DIM);
  localparam int unsigned CHAR_ADVANCE  = 9;
  localparam int unsigned LINE_ADVANCE  = 10;

  localparam int unsigned SIZE_W  = 13;
  localparam int unsigned COLOR_W = 32;
  localparam int unsigned INDEX_W = 24;
  localparam int unsigned POS_W   = 16;

  localparam logic [SIZE_W-1:0]  RST_SCREEN_WIDTH  = 13'd1024;
  localparam logic [SIZE_W-1:0]  RST_SCREEN_HEIGHT = 13'd768;
  localparam logic [COLOR_W-1:0] RST_TRANS_KEY     = 32'h00FF_00FF;

  localparam int unsigned S_TDATA_W = 128;
  localparam int unsigned M_TDATA_W = 96;

  typedef struct packed {
    logic                 valid;
    logic                 last;
    logic [ROW_SEL_W-1:0] col;
  } pix_ctl_t;

endpackage

`default_nettype wire

// File: hdl/bft_ram.sv
`default_nettype none

module bft_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 768
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: hdl/bft_pix.sv
`default_nettype none

module bft_pix
  import bft_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  output      logic                   adv_o,
  input  wire pix_ctl_t               iss_i,
  input  wire logic [COORD_WIDTH-1:0] px_i,
  input  wire logic [COORD_WIDTH-1:0] py_i,
  input  wire logic [COLOR_W-1:0]     fg_i,
  input  wire logic [COLOR_W-1:0]     bg_i,
  input  wire logic                   bgv_i,
  input  wire logic [GLYPH_DIM-1:0]   rdata_i,
  input  wire logic [SIZE_W-1:0]      screen_width_i,
  input  wire logic [SIZE_W-1:0]      screen_height_i,
  output      logic                   m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output      logic [M_TDATA_W-1:0]   m_axis_tdata,  // write_enable, pixel_x, pixel_y,
                                                     // pixel_index, pixel_color
  output      logic                   m_axis_tlast   // last_pixel
);

  localparam int unsigned CW = COORD_WIDTH;

  logic adv;

  pix_ctl_t          s1_ctl_q;
  logic [CW-1:0]     s1_px_q, s1_py_q;
  logic [COLOR_W-1:0] s1_fg_q, s1_bg_q;
  logic              s1_bgv_q;

  logic              s2_valid_q, s2_last_q, s2_set_q, s2_in_q, s2_bgv_q;
  logic [CW-1:0]     s2_px_q, s2_py_q;
  logic [INDEX_W-1:0] s2_prod_q;
  logic [COLOR_W-1:0] s2_fg_q, s2_bg_q;

  logic              out_valid_q, out_last_q, out_we_q;
  logic [POS_W-1:0]  out_x_q, out_y_q;
  logic [INDEX_W-1:0] out_idx_q;
  logic [COLOR_W-1:0] out_color_q;

  logic              s1_set, s1_in, s2_en;
  logic [INDEX_W-1:0] s1_prod;

  assign adv   = !out_valid_q || m_axis_tready;
  assign adv_o = adv;

  always_comb begin
    s1_set  = rdata_i[ROW_SEL_W'(GLYPH_DIM - 1) - s1_ctl_q.col];
    s1_in   = !s1_px_q[CW-1] && !s1_py_q[CW-1] &&
              (s1_px_q < CW'(screen_width_i)) && (s1_py_q < CW'(screen_height_i));
    s1_prod = INDEX_W'(INDEX_W'(s1_py_q) * screen_width_i);
    s2_en   = s2_in_q && (s2_set_q || s2_bgv_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_ctl_q    <= '0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_ctl_q    <= iss_i;
      s2_valid_q  <= s1_ctl_q.valid;
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_px_q  <= px_i;
      s1_py_q  <= py_i;
      s1_fg_q  <= fg_i;
      s1_bg_q  <= bg_i;
      s1_bgv_q <= bgv_i;

      s2_last_q <= s1_ctl_q.last;
      s2_set_q  <= s1_set;
      s2_in_q   <= s1_in;
      s2_bgv_q  <= s1_bgv_q;
      s2_px_q   <= s1_px_q;
      s2_py_q   <= s1_py_q;
      s2_prod_q <= s1_prod;
      s2_fg_q   <= s1_fg_q;
      s2_bg_q   <= s1_bg_q;

      out_last_q  <= s2_last_q;
      out_we_q    <= s2_en;
      out_x_q     <= POS_W'(s2_px_q);
      out_y_q     <= POS_W'(s2_py_q);
      out_idx_q   <= s2_en ? s2_prod_q + INDEX_W'(s2_px_q) : '0;
      out_color_q <= s2_en ? (s2_set_q ? s2_fg_q : s2_bg_q) : '0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {(M_TDATA_W - 1 - 2*POS_W - INDEX_W - COLOR_W)'(0),
                          out_color_q, out_idx_q, out_y_q, out_x_q, out_we_q};

`ifndef ASSERT_OFF
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(s1_px_q) && $stable(s1_py_q) && $stable(s1_ctl_q))
    else $error("stage one moved during stall");
`endif

endmodule

`default_nettype wire

// File: hdl/bitmap_font_text_renderer.sv
// An accepted draw word moves the block to its draw state; each pixel then passes the
// font-store read with stage one, then stage two and the output register to m_axis.
// Throughput: a drawn character issues 64 pixels with the input held (one font-store read
// per pixel, one pixel a cycle while m_axis does not stall); origin, newline and font
// words leave it idle. Reset: the font store is cleared by a pass over GLYPH_COUNT*8
// rows (768 by default) with s_axis_tready low; config writes are taken throughout.
`default_nettype none

module bitmap_font_text_renderer
  import bft_pkg::*;
#(
  parameter int unsigned GLYPH_COUNT = 96,
  parameter int unsigned COORD_WIDTH = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  output      logic                 s_axis_tready,
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata,  // pos_x, pos_y, char_code, fg_color,
                                                   // bg_color, glyph_slot, glyph_row, row_bits
  input  wire logic [1:0]           s_axis_tuser,  // opcode
  output      logic                 m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output      logic [M_TDATA_W-1:0] m_axis_tdata,  // write_enable, pixel_x, pixel_y,
                                                   // pixel_index, pixel_color
  output      logic                 m_axis_tlast,  // last_pixel
  input  wire logic                 cfg_we_i,
  input  wire logic [1:0]           cfg_idx_i,
  input  wire logic [COLOR_W-1:0]   cfg_data_i
);

  localparam int unsigned CW    = COORD_WIDTH;
  localparam int unsigned DEPTH = GLYPH_COUNT * GLYPH_DIM;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned IW    = AW - ROW_SEL_W;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_DRAW  = 2'd2;

  logic [1:0]          state_q, state_d;
  logic [AW-1:0]       clr_cnt_q, clr_cnt_d;
  logic [PIX_CNT_W-1:0] cnt_q, cnt_d;
  logic [CW-1:0]       origin_q, origin_d, cur_col_q, cur_col_d, cur_row_q, cur_row_d;
  logic [IW-1:0]       glyph_q, glyph_d;
  logic [COLOR_W-1:0]  fg_q, fg_d, bg_q, bg_d;
  logic                bgv_q, bgv_d;
  logic [SIZE_W-1:0]   sw_q, sh_q;
  logic [COLOR_W-1:0]  key_q;

  logic signed [POS_W-1:0] in_pos_x, in_pos_y;
  logic [7:0]          in_code, in_row_bits;
  logic [COLOR_W-1:0]  in_fg, in_bg;
  logic [6:0]          in_slot;
  logic [2:0]          in_row;
  logic                accept, code_ok, adv, iss_fire;

  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [GLYPH_DIM-1:0] ram_wdata, ram_rdata;

  pix_ctl_t            iss;
  logic [CW-1:0]       iss_px, iss_py;

  assign in_pos_x    = signed'(s_axis_tdata[15:0]);
  assign in_pos_y    = signed'(s_axis_tdata[31:16]);
  assign in_code     = s_axis_tdata[39:32];
  assign in_fg       = s_axis_tdata[71:40];
  assign in_bg       = s_axis_tdata[103:72];
  assign in_slot     = s_axis_tdata[110:104];
  assign in_row      = s_axis_tdata[113:111];
  assign in_row_bits = s_axis_tdata[121:114];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign code_ok       = (in_code >= CH_FIRST) &&
                         ({1'b0, in_code - CH_FIRST} < 9'(GLYPH_COUNT));

  assign iss.valid = (state_q == ST_DRAW);
  assign iss.last  = &cnt_q;
  assign iss.col   = cnt_q[ROW_SEL_W-1:0];
  assign iss_px    = cur_col_q + CW'(cnt_q[ROW_SEL_W-1:0]);
  assign iss_py    = cur_row_q + CW'(cnt_q[PIX_CNT_W-1:ROW_SEL_W]);
  assign iss_fire  = iss.valid && adv;

  assign ram_re    = iss_fire;
  assign ram_raddr = {glyph_q, cnt_q[PIX_CNT_W-1:ROW_SEL_W]};

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = {IW'(in_slot), in_row};
    ram_wdata = in_row_bits;
    if (state_q == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_q;
      ram_wdata = '0;
    end else if (accept && s_axis_tuser == OP_FONT &&
                 {2'b0, in_slot} < 9'(GLYPH_COUNT)) begin
      ram_we = 1'b1;
    end
  end

  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    cnt_d     = cnt_q;
    origin_d  = origin_q;
    cur_col_d = cur_col_q;
    cur_row_d = cur_row_q;
    glyph_d   = glyph_q;
    fg_d      = fg_q;
    bg_d      = bg_q;
    bgv_d     = bgv_q;
    unique case (state_q)
      ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == AW'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept && s_axis_tuser == OP_ORIGIN) begin
          origin_d  = CW'(in_pos_x);
          cur_col_d = CW'(in_pos_x);
          cur_row_d = CW'(in_pos_y);
        end else if (accept && s_axis_tuser == OP_DRAW) begin
          if (in_code == CH_NEWLINE) begin
            cur_col_d = origin_q;
            cur_row_d = cur_row_q + CW'(LINE_ADVANCE);
          end else begin
            glyph_d = code_ok ? IW'(in_code - CH_FIRST) : IW'(CH_UNKNOWN - CH_FIRST);
            fg_d    = in_fg;
            bg_d    = in_bg;
            bgv_d   = (in_bg != key_q);
            cnt_d   = '0;
            state_d = ST_DRAW;
          end
        end
      end
      ST_DRAW: begin
        if (iss_fire) begin
          cnt_d = cnt_q + 1'b1;
          if (&cnt_q) begin
            cur_col_d = cur_col_q + CW'(CHAR_ADVANCE);
            state_d   = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
      cnt_q     <= '0;
      origin_q  <= '0;
      cur_col_q <= '0;
      cur_row_q <= '0;
      sw_q      <= RST_SCREEN_WIDTH;
      sh_q      <= RST_SCREEN_HEIGHT;
      key_q     <= RST_TRANS_KEY;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      cnt_q     <= cnt_d;
      origin_q  <= origin_d;
      cur_col_q <= cur_col_d;
      cur_row_q <= cur_row_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_SCREEN_WIDTH:  sw_q  <= cfg_data_i[SIZE_W-1:0];
          REG_SCREEN_HEIGHT: sh_q  <= cfg_data_i[SIZE_W-1:0];
          REG_TRANS_KEY:     key_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    glyph_q <= glyph_d;
    fg_q    <= fg_d;
    bg_q    <= bg_d;
    bgv_q   <= bgv_d;
  end

  bft_ram #(
    .WIDTH (GLYPH_DIM),
    .DEPTH (DEPTH)
  ) u_font (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  bft_pix #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_pix (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .adv_o           (adv),
    .iss_i           (iss),
    .px_i            (iss_px),
    .py_i            (iss_py),
    .fg_i            (fg_q),
    .bg_i            (bg_q),
    .bgv_i           (bgv_q),
    .rdata_i         (ram_rdata),
    .screen_width_i  (sw_q),
    .screen_height_i (sh_q),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .m_axis_tlast    (m_axis_tlast)
  );

`ifndef ASSERT_OFF
  a_no_write_in_draw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAW) |-> !ram_we)
    else $error("font store written during a draw");

  a_draw_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (iss_fire && (&cnt_q)) |=> (state_q == ST_IDLE) && (cnt_q == '0))
    else $error("draw did not end after the last pixel");

  a_cursor_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!accept && !(iss_fire && (&cnt_q))) |=> $stable(cur_col_q) && $stable(cur_row_q))
    else $error("cursor moved without a word");

  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !s_axis_tready && !iss.valid)
    else $error("work started during clearing pass");
`endif

endmodule

`default_nettype wire
